/* hw/rtl/gregorian_date_add_days_macros.svh */
// Assertion macros shared by the date adder RTL.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef GREGORIAN_DATE_ADD_DAYS_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GDAD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("date adder assertion failed");

// Next-cycle implication, checked out of reset.
`define GDAD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("date adder assertion failed");

`endif

/* hw/rtl/gdad_pkg.sv */
// Shared types, constants and calendar functions for the date adder.
// No dependencies; used by gdad_core and the top level.
`timescale 1ns / 1ps

package gdad_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 16;

	// Years per Gregorian leap cycle and the first shift of the residue search
	localparam logic [15:0] CYCLE_LEN     = 16'd400;
	localparam logic [2:0]  MOD_TOP_SHIFT = 3'd5;
	localparam logic [8:0]  CYCLE_LAST    = 9'd399;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_CHECK,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               invalid_date;
		logic               year_overflow;
	} result_t;

	// Leap test from the year modulo 400
	function automatic logic is_leap(input logic [8:0] rem);
		is_leap = (rem[1:0] == 2'b00) && (rem != 9'd100) && (rem != 9'd200)
			&& (rem != 9'd300);
	endfunction

	// Month length; codes outside 1..12 return 31 and are rejected elsewhere
	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd2:    len = leap ? 5'd29 : 5'd28;
			4'd4:    len = 5'd30;
			4'd6:    len = 5'd30;
			4'd9:    len = 5'd30;
			4'd11:   len = 5'd30;
			default: len = 5'd31;
		endcase
		days_in = len;
	endfunction

endpackage

/* hw/rtl/gdad_alu.sv */
// Shared 16-bit subtract and compare unit of the date adder.
// Standalone; driven by the sequencer in gdad_core.
`timescale 1ns / 1ps

module gdad_alu (
	input  logic [15:0] a,
	input  logic [15:0] b,
	output logic [15:0] diff,
	output logic        ge
);

	logic [16:0] wide;

	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[15:0];
	assign ge   = ~wide[16];

endmodule

/* hw/rtl/gdad_core.sv */
// Sequencer and datapath registers of the date adder: year residue search,
// date check and the month-by-month walk. Uses gdad_pkg and gdad_alu.
`timescale 1ns / 1ps

module gdad_core #(
	parameter int MAX_YEAR = 9999
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [gdad_pkg::YEAR_W-1:0]  in_year,
	input  logic [gdad_pkg::MONTH_W-1:0] in_month,
	input  logic [gdad_pkg::DAY_W-1:0]   in_day,
	input  logic [gdad_pkg::COUNT_W-1:0] in_count,
	input  logic                       out_free,
	output logic                       idle,
	output logic                       done,
	output gdad_pkg::result_t          result
);

	localparam int YW_MAX = $clog2(MAX_YEAR + 2);
	localparam int YW     = (YW_MAX > gdad_pkg::YEAR_W) ? YW_MAX : gdad_pkg::YEAR_W;
	localparam logic [YW-1:0] MAX_Y = YW'(MAX_YEAR);

	gdad_pkg::state_t state_q, state_d;

	logic [YW-1:0]                 y_q;
	logic [gdad_pkg::MONTH_W-1:0]  m_q;
	logic [gdad_pkg::DAY_W-1:0]    d_q;
	logic [gdad_pkg::COUNT_W-1:0]  n_q;
	logic [13:0]                   rem_q;
	logic [2:0]                    k_q;
	logic                          inv_q;
	logic                          ovf_q;

	logic [15:0]                   alu_a, alu_b, alu_diff;
	logic                          alu_ge;
	logic                          leap;
	logic [gdad_pkg::DAY_W-1:0]    len;
	logic [gdad_pkg::DAY_W-1:0]    room;
	logic                          date_ok;
	logic [YW-1:0]                 y_inc;
	logic [13:0]                   mod_src;

	// After the search rem_q holds the year modulo 400 in its low bits
	assign leap  = gdad_pkg::is_leap(rem_q[8:0]);
	assign len   = gdad_pkg::days_in(m_q, leap);
	assign room  = len - d_q;
	assign y_inc = y_q + YW'(1);

	assign date_ok = (m_q >= gdad_pkg::MONTH_JAN) && (m_q <= gdad_pkg::MONTH_DEC)
		&& (y_q <= MAX_Y) && (d_q != '0) && (d_q <= len);

	// Residue search works on the 14-bit input year held in y_q
	assign mod_src = (k_q == gdad_pkg::MOD_TOP_SHIFT) ? y_q[13:0] : rem_q;

	always_comb begin
		case (state_q)
			gdad_pkg::ST_MOD: begin
				alu_a = 16'(mod_src);
				alu_b = gdad_pkg::CYCLE_LEN << k_q;
			end
			default: begin
				alu_a = n_q;
				alu_b = 16'(room) + 16'd1;
			end
		endcase
	end

	gdad_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gdad_pkg::ST_IDLE:  if (start) state_d = gdad_pkg::ST_MOD;
			gdad_pkg::ST_MOD:   if (k_q == 3'd0) state_d = gdad_pkg::ST_CHECK;
			gdad_pkg::ST_CHECK: begin
				if (!date_ok || n_q == '0)
					state_d = gdad_pkg::ST_DONE;
				else
					state_d = gdad_pkg::ST_WALK;
			end
			gdad_pkg::ST_WALK: begin
				if (!alu_ge)
					state_d = gdad_pkg::ST_DONE;
				else if (m_q == gdad_pkg::MONTH_DEC && y_inc > MAX_Y)
					state_d = gdad_pkg::ST_DONE;
			end
			gdad_pkg::ST_DONE:  if (out_free) state_d = gdad_pkg::ST_IDLE;
			default:            state_d = gdad_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		idle = 1'b0;
		done = 1'b0;
		case (state_q)
			gdad_pkg::ST_IDLE: idle = 1'b1;
			gdad_pkg::ST_DONE: done = 1'b1;
			default: ;
		endcase
	end

	assign result.year          = y_q[gdad_pkg::YEAR_W-1:0];
	assign result.month         = m_q;
	assign result.day           = d_q;
	assign result.invalid_date  = inv_q;
	assign result.year_overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdad_pkg::ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == gdad_pkg::ST_IDLE)
				k_q <= gdad_pkg::MOD_TOP_SHIFT;
			else if (state_q == gdad_pkg::ST_MOD && k_q != 3'd0)
				k_q <= k_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gdad_pkg::ST_IDLE: begin
				if (start) begin
					y_q   <= YW'(in_year);
					m_q   <= in_month;
					d_q   <= in_day;
					n_q   <= in_count;
					inv_q <= 1'b0;
					ovf_q <= 1'b0;
				end
			end
			gdad_pkg::ST_MOD: begin
				// Restoring subtract of 400 << k, high shift first
				rem_q <= alu_ge ? alu_diff[13:0] : mod_src;
			end
			gdad_pkg::ST_CHECK: begin
				inv_q <= ~date_ok;
			end
			gdad_pkg::ST_WALK: begin
				if (!alu_ge) begin
					d_q <= d_q + n_q[gdad_pkg::DAY_W-1:0];
					n_q <= '0;
				end else begin
					n_q <= alu_diff;
					d_q <= 5'd1;
					if (m_q == gdad_pkg::MONTH_DEC) begin
						if (y_inc > MAX_Y) begin
							// Saturate at the last day of the last year
							y_q   <= MAX_Y;
							d_q   <= gdad_pkg::DAY_LAST_DEC;
							ovf_q <= 1'b1;
							n_q   <= '0;
						end else begin
							m_q   <= gdad_pkg::MONTH_JAN;
							y_q   <= y_inc;
							rem_q <= (rem_q[8:0] == gdad_pkg::CYCLE_LAST) ? '0
								: rem_q + 14'd1;
						end
					end else begin
						m_q <= m_q + 4'd1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

/* hw/rtl/gregorian_date_add_days.sv */
// Top level of the Gregorian date adder: stream ports and result register.
// Uses gdad_pkg, gdad_core and gregorian_date_add_days_macros.svh.
//
//  channel  dir  payload (lsb first)                            accepted when
//  s_axis   in   tdata: start_year, start_month, start_day,      tvalid & tready
//                       days_to_add
//  m_axis   out  tdata: result_year, result_month, result_day;   tvalid & tready
//                tuser: invalid_date, year_overflow
//
// Each beat runs the residue search, the date check and then, unless the count is
// zero or the date invalid, a walk over M months (up to about 2154 for a count of
// 65535). The shared subtract unit handles one residue step or one month per cycle.
// s_axis_tready is high only while idle.
// A result waits in the output register; the core holds it until that register
// frees up. Reset clears the sequencer and the output valid.
`timescale 1ns / 1ps
`include "gregorian_date_add_days_macros.svh"

module gregorian_date_add_days #(
	parameter int MAX_YEAR = 9999
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // start_year, start_month, start_day, days_to_add
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // result_year, result_month, result_day
	output logic [1:0]  m_axis_tuser   // invalid_date, year_overflow
);

	logic              idle;
	logic              done;
	logic              out_free;
	gdad_pkg::result_t result;
	gdad_pkg::result_t out_q;
	logic              out_valid_q;
	logic              res_month_ok;
	logic              res_last_day;

	assign s_axis_tready = idle;
	assign out_free      = !out_valid_q || m_axis_tready;

	gdad_core #(
		.MAX_YEAR (MAX_YEAR)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_axis_tvalid && idle),
		.in_year  (s_axis_tdata[13:0]),
		.in_month (s_axis_tdata[17:14]),
		.in_day   (s_axis_tdata[22:18]),
		.in_count (s_axis_tdata[38:23]),
		.out_free (out_free),
		.idle     (idle),
		.done     (done),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free)
			out_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.day, out_q.month, out_q.year};
	assign m_axis_tuser  = {out_q.year_overflow, out_q.invalid_date};

	assign res_month_ok = (m_axis_tdata[17:14] >= gdad_pkg::MONTH_JAN)
		&& (m_axis_tdata[17:14] <= gdad_pkg::MONTH_DEC);
	assign res_last_day = (m_axis_tdata[17:14] == gdad_pkg::MONTH_DEC)
		&& (m_axis_tdata[22:18] == gdad_pkg::DAY_LAST_DEC);

	`GDAD_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`GDAD_ASSERT_IMP(a_flags_exclusive, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
	`GDAD_ASSERT_IMP(a_month_range, m_axis_tvalid && !m_axis_tuser[0], res_month_ok)
	`GDAD_ASSERT_IMP(a_ovf_saturated, m_axis_tvalid && m_axis_tuser[1], res_last_day)
	`GDAD_ASSERT_IMP(a_done_not_idle, done, !idle)

endmodule

/* test/tb.sv */
// Self-checking bench for gregorian_date_add_days: stream stimulus, calendar predictor,
// in-order result scoreboard. Depends on gdad_pkg and the gregorian_date_add_days RTL.
`timescale 1ns / 1ps

class date_scoreboard;
	int unsigned max_year;
	gdad_pkg::result_t awaited[$];
	int errors;
	int n_inputs;
	int n_results;
	int n_invalid;
	int n_overflow;
	int n_long;

	function new(int unsigned year_limit);
		max_year = year_limit;
		errors = 0;
		n_inputs = 0;
		n_results = 0;
		n_invalid = 0;
		n_overflow = 0;
		n_long = 0;
	endfunction

	function automatic bit leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(int unsigned y, int unsigned m);
		int unsigned lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m == 32'(gdad_pkg::MONTH_FEB) && leap_year(y))
			return 29;
		return lengths[m - 1];
	endfunction

	// Check the start date, then walk forward a month at a time until the count is used up or the calendar ends
	function automatic gdad_pkg::result_t advance_date(logic [gdad_pkg::YEAR_W-1:0] y_in,
			logic [gdad_pkg::MONTH_W-1:0] m_in, logic [gdad_pkg::DAY_W-1:0] d_in,
			logic [gdad_pkg::COUNT_W-1:0] n_in);
		int unsigned y, m, d, n, room;
		gdad_pkg::result_t r;
		y = 32'(y_in);
		m = 32'(m_in);
		d = 32'(d_in);
		n = 32'(n_in);
		r = '0;
		if (m < 32'(gdad_pkg::MONTH_JAN) || m > 32'(gdad_pkg::MONTH_DEC) || y > max_year
				|| d < 1 || d > month_days(y, m)) begin
			r.invalid_date = 1'b1;
		end else begin
			while (n > 0) begin
				room = month_days(y, m) - d;
				if (n <= room) begin
					d += n;
					n = 0;
				end else begin
					n -= room + 1;
					d = 1;
					if (m == 32'(gdad_pkg::MONTH_DEC)) begin
						m = 32'(gdad_pkg::MONTH_JAN);
						y++;
						if (y > max_year) begin
							y = max_year;
							m = 32'(gdad_pkg::MONTH_DEC);
							d = 32'(gdad_pkg::DAY_LAST_DEC);
							r.year_overflow = 1'b1;
							n = 0;
						end
					end else begin
						m++;
					end
				end
			end
		end
		r.year = y[gdad_pkg::YEAR_W-1:0];
		r.month = m[gdad_pkg::MONTH_W-1:0];
		r.day = d[gdad_pkg::DAY_W-1:0];
		return r;
	endfunction

	function void note_input(logic [gdad_pkg::YEAR_W-1:0] y, logic [gdad_pkg::MONTH_W-1:0] m,
			logic [gdad_pkg::DAY_W-1:0] d, logic [gdad_pkg::COUNT_W-1:0] n);
		gdad_pkg::result_t r;
		r = advance_date(y, m, d, n);
		awaited.push_back(r);
		n_inputs++;
		if (r.invalid_date)
			n_invalid++;
		if (r.year_overflow)
			n_overflow++;
		if (n > 16'd20000)
			n_long++;
	endfunction

	task report_mismatch(string what, int got, int want);
		$display("[%0t] MISMATCH on %s: got %0d, want %0d", $realtime, what, got, want);
		errors++;
	endtask

	task check_result(logic [23:0] data, logic [1:0] flags);
		gdad_pkg::result_t want;
		n_results++;
		if (awaited.size() == 0) begin
			report_mismatch("outstanding beats at result", 0, 1);
		end else begin
			want = awaited.pop_front();
			if (data[13:0] != want.year)
				report_mismatch("result_year", int'(data[13:0]), int'(want.year));
			if (data[17:14] != want.month)
				report_mismatch("result_month", int'(data[17:14]), int'(want.month));
			if (data[22:18] != want.day)
				report_mismatch("result_day", int'(data[22:18]), int'(want.day));
			if (flags[0] != want.invalid_date)
				report_mismatch("invalid_date", int'(flags[0]), int'(want.invalid_date));
			if (flags[1] != want.year_overflow)
				report_mismatch("year_overflow", int'(flags[1]), int'(want.year_overflow));
		end
	endtask

	function int pending();
		return awaited.size();
	endfunction
endclass

module tb;

	localparam int unsigned MAX_YEAR = 9999;
	localparam int LIMIT_CYCLES = 3000000;
	localparam int N_RANDOM = 250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // start_year, start_month, start_day, days_to_add
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // result_year, result_month, result_day
	logic [1:0]  m_axis_tuser;        // invalid_date, year_overflow

	bit steady = 1'b0;
	int cycles = 0;
	date_scoreboard dates = new(MAX_YEAR);

	gregorian_date_add_days #(.MAX_YEAR(MAX_YEAR)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, dates.pending());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pause_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			dates.check_result(m_axis_tdata, m_axis_tuser);
	end

	initial begin : drain
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
				hold = pause_len();
			end
		end
	end

	task send_date(logic [gdad_pkg::YEAR_W-1:0] y, logic [gdad_pkg::MONTH_W-1:0] m,
			logic [gdad_pkg::DAY_W-1:0] d, logic [gdad_pkg::COUNT_W-1:0] n);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, n, d, m, y};
		do @(posedge clk); while (!s_axis_tready);
		dates.note_input(y, m, d, n);
	endtask

	// Drop valid and let every outstanding result drain
	task drain_all();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (dates.pending() != 0)
			@(posedge clk);
	endtask

	task send_random();
		int unsigned y, m, d, n, r, len;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			// noise: any field pattern, mostly invalid
			send_date(14'($urandom), 4'($urandom), 5'($urandom), 16'($urandom));
		end else begin
			y = ($urandom_range(0, 99) < 15) ? $urandom_range(MAX_YEAR - 180, MAX_YEAR)
				: $urandom_range(0, MAX_YEAR);
			m = $urandom_range(32'(gdad_pkg::MONTH_JAN), 32'(gdad_pkg::MONTH_DEC));
			len = dates.month_days(y, m);
			d = ($urandom_range(0, 99) < 30) ? len : $urandom_range(1, len);
			r = $urandom_range(0, 99);
			if (r < 55)
				n = $urandom_range(0, 100);
			else if (r < 82)
				n = $urandom_range(0, 2000);
			else if (r < 94)
				n = $urandom_range(0, 20000);
			else
				n = $urandom_range(0, 65535);
			send_date(y[gdad_pkg::YEAR_W-1:0], m[gdad_pkg::MONTH_W-1:0],
				d[gdad_pkg::DAY_W-1:0], n[gdad_pkg::COUNT_W-1:0]);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		steady = 1'b1;
		send_date(14'd2024, gdad_pkg::MONTH_FEB, 5'd28, 16'd0);
		send_date(14'd0, gdad_pkg::MONTH_JAN, 5'd1, 16'hFFFF);
		send_date(14'd9999, gdad_pkg::MONTH_DEC, 5'd31, 16'd0);
		send_date(14'd9999, gdad_pkg::MONTH_DEC, 5'd31, 16'd1);
		send_date(14'd9999, gdad_pkg::MONTH_JAN, 5'd1, 16'hFFFF);
		send_date(14'd9999, gdad_pkg::MONTH_DEC, 5'd30, 16'd1);
		send_date(14'd1999, gdad_pkg::MONTH_DEC, 5'd31, 16'd1);
		send_date(14'd1900, gdad_pkg::MONTH_FEB, 5'd28, 16'd1);
		send_date(14'd2000, gdad_pkg::MONTH_FEB, 5'd29, 16'd1);
		send_date(14'd2024, gdad_pkg::MONTH_FEB, 5'd29, 16'd365);
		send_date(14'd2100, gdad_pkg::MONTH_FEB, 5'd28, 16'd1);
		send_date(14'd2023, gdad_pkg::MONTH_JAN, 5'd31, 16'd31);
		// invalid start dates, then one valid start in year 400
		send_date(14'd2020, 4'd0, 5'd10, 16'd5);
		send_date(14'd2020, 4'd13, 5'd10, 16'd5);
		send_date(14'd2020, 4'd15, 5'd1, 16'd0);
		send_date(14'd2020, gdad_pkg::MONTH_JAN, 5'd0, 16'd5);
		send_date(14'd2021, 4'd4, 5'd31, 16'd5);
		send_date(14'd1900, gdad_pkg::MONTH_FEB, 5'd29, 16'd5);
		send_date(14'd2023, gdad_pkg::MONTH_FEB, 5'd29, 16'd1);
		send_date(14'd10000, gdad_pkg::MONTH_JAN, 5'd1, 16'd1);
		send_date(14'h3FFF, 4'hF, 5'h1F, 16'hFFFF);
		send_date(14'd400, gdad_pkg::MONTH_DEC, 5'd31, 16'd59);
		drain_all();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 50 == 0)
				steady = (i / 50) % 3 == 2;
			if (i == N_RANDOM / 2)
				drain_all();
			send_random();
		end
		drain_all();
		repeat (20) @(posedge clk);

		$display("Covered %0d dates: %0d rejected as invalid, %0d saturated at the top year,",
			dates.n_inputs, dates.n_invalid, dates.n_overflow);
		$display("%0d counts above 20000 days, %0d results checked", dates.n_long,
			dates.n_results);
		if (dates.errors == 0 && dates.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/gdad_pkg.sv
hw/rtl/gdad_alu.sv
hw/rtl/gdad_core.sv
hw/rtl/gregorian_date_add_days.sv
test/tb.sv
